// ===== sv/sin_pkg.sv =====
// shared types and constants for the slice index normalizer
package sin_pkg;

  localparam int unsigned FieldW = 32;
  localparam int unsigned DimW   = 31;
  localparam int unsigned CalcW  = 34;
  localparam int unsigned QuotW  = 31;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IDX_OOB = 2'd1,
    ST_RNG_OOB = 2'd2
  } status_t;

  // result fields that ride along the divider
  typedef struct packed {
    status_t               status;
    logic                  remove_dim;
    logic [DimW-1:0]       first_index;
    logic [FieldW-1:0]     index_stride;
    logic [DimW-1:0]       fixed_length;
    logic                  use_quot;
  } meta_t;

endpackage

// ===== sv/sin_if.sv =====
// request and response channel interfaces
interface sin_req_if import sin_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [FieldW-1:0] range_start;
  logic signed [FieldW-1:0] range_finish;
  logic signed [FieldW-1:0] range_step;
  logic [DimW-1:0]          dim_size;

  modport source (output valid, range_start, range_finish, range_step, dim_size,
                  input ready);
  modport sink   (input valid, range_start, range_finish, range_step, dim_size,
                  output ready);
endinterface

interface sin_rsp_if import sin_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic                     remove_dim;
  logic [DimW-1:0]          first_index;
  logic signed [FieldW-1:0] index_stride;
  logic [DimW-1:0]          result_length;

  modport source (output valid, status, remove_dim, first_index, index_stride,
                  result_length, input ready);
  modport sink   (input valid, status, remove_dim, first_index, index_stride,
                  result_length, output ready);
endinterface

// ===== sv/sin_norm.sv =====
// two-stage bounds check and span computation ahead of the divider
module sin_norm import sin_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [FieldW-1:0]        in_start,
  input  logic [FieldW-1:0]        in_finish,
  input  logic [FieldW-1:0]        in_step,
  input  logic [DimW-1:0]          in_dim,
  output logic                     out_valid,
  output meta_t                    out_meta,
  output logic [QuotW-1:0]         out_num,
  output logic [FieldW-1:0]        out_mag
);

  localparam logic signed [CalcW-1:0] SMin = -(CalcW'(1) <<< (W - 1));
  localparam logic signed [CalcW-1:0] SMax = (CalcW'(1) <<< (W - 1)) - CalcW'(1);

  logic signed [W-1:0]     st_w, fi_w, sp_w;
  logic signed [CalcW-1:0] s, e, p, d;
  logic                    pos;

  assign st_w = in_start[W-1:0];
  assign fi_w = in_finish[W-1:0];
  assign sp_w = in_step[W-1:0];
  assign s    = CalcW'(st_w);
  assign e    = CalcW'(fi_w);
  assign p    = CalcW'(sp_w);
  assign d    = $signed({3'b000, in_dim});
  assign pos  = (p > 0);

  // stage a: normalize start and finish
  logic                    a_single_next, a_bad_next;
  logic signed [CalcW-1:0] a_start_next, a_end_next;

  always_comb begin
    a_single_next = (p == 0);
    a_bad_next    = 1'b0;
    a_start_next  = s;
    a_end_next    = e;
    if (s >= 0) begin
      if (s >= d) a_bad_next = 1'b1;
    end else if (s >= -d) begin
      a_start_next = s + d;
    end else if (!a_single_next && s == SMin) begin
      a_start_next = pos ? '0 : d - CalcW'(1);
    end else begin
      a_bad_next = 1'b1;
    end
    if (!a_single_next) begin
      if (e >= 0) begin
        if (pos ? (e > d) : (e >= d)) begin
          if (e == SMax) a_end_next = pos ? d : -CalcW'(1);
          else           a_bad_next = 1'b1;
        end
      end else if (e >= -d) begin
        a_end_next = e + d;
      end else begin
        a_bad_next = 1'b1;
      end
    end
  end

  logic                    a_valid, a_single, a_bad;
  logic signed [CalcW-1:0] a_start, a_end, a_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_single <= a_single_next;
      a_bad    <= a_bad_next;
      a_start  <= a_start_next;
      a_end    <= a_end_next;
      a_step   <= p;
    end
  end

  // stage b: span, magnitude and result classification
  logic signed [CalcW-1:0] span, mag;
  meta_t                   meta_next;
  logic [QuotW-1:0]        num_next;

  always_comb begin
    span      = (a_step > 0) ? a_end - a_start : a_start - a_end;
    mag       = (a_step > 0) ? a_step : -a_step;
    meta_next = '0;
    num_next  = QuotW'(span - CalcW'(1));
    if (a_bad) begin
      meta_next.status = a_single ? ST_IDX_OOB : ST_RNG_OOB;
    end else if (a_single) begin
      meta_next.status       = ST_OK;
      meta_next.remove_dim   = 1'b1;
      meta_next.first_index  = a_start[DimW-1:0];
      meta_next.index_stride = FieldW'(1);
      meta_next.fixed_length = DimW'(1);
    end else if (span <= 0) begin
      meta_next.status       = ST_OK;
      meta_next.index_stride = FieldW'(1);
    end else begin
      meta_next.status       = ST_OK;
      meta_next.first_index  = a_start[DimW-1:0];
      meta_next.index_stride = a_step[FieldW-1:0];
      meta_next.use_quot     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_meta <= meta_next;
      out_num  <= num_next;
      out_mag  <= mag[FieldW-1:0];
    end
  end

endmodule

// ===== sv/sin_div.sv =====
// restoring divider, one quotient bit per pipeline stage
module sin_div import sin_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  meta_t             in_meta,
  input  logic [QuotW-1:0]  in_num,
  input  logic [FieldW-1:0] in_mag,
  output logic              out_valid,
  output meta_t             out_meta,
  output logic [QuotW-1:0]  out_quot
);

  localparam int unsigned N = QuotW;

  logic              vld  [0:N];
  meta_t             meta [0:N];
  logic [QuotW-1:0]  num  [0:N];
  logic [FieldW-1:0] mag  [0:N];
  logic [FieldW-1:0] rem  [0:N];
  logic [QuotW-1:0]  quot [0:N];

  assign vld[0]  = in_valid;
  assign meta[0] = in_meta;
  assign num[0]  = in_num;
  assign mag[0]  = in_mag;
  assign rem[0]  = '0;
  assign quot[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [FieldW:0]   trial;
    logic              ge;
    logic [FieldW-1:0] rem_next;

    always_comb begin
      trial    = {rem[k], num[k][N-1-k]};
      ge       = (trial >= {1'b0, mag[k]});
      rem_next = ge ? FieldW'(trial - {1'b0, mag[k]}) : trial[FieldW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta[k+1] <= meta[k];
        num[k+1]  <= num[k];
        mag[k+1]  <= mag[k];
        rem[k+1]  <= rem_next;
        quot[k+1] <= {quot[k][QuotW-2:0], ge};
      end
    end
  end

  assign out_valid = vld[N];
  assign out_meta  = meta[N];
  assign out_quot  = quot[N];

endmodule

// ===== sv/slice_index_normalizer.sv =====
// slice_index_normalizer: 2 normalize stages, 31 divider stages, 1 output register
// throughput one beat per cycle while the output beat is taken; the length divider retires one quotient bit per stage
// the whole pipeline advances together and holds while the output beat is not taken
// reset (rst, synchronous, active high) clears every stage valid bit and the output valid
module slice_index_normalizer import sin_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  sin_req_if.sink   req,
  sin_rsp_if.source rsp
);

  // effective index width, fields wider than 32 bits are not carried
  localparam int unsigned W = (INDEX_WIDTH > 32) ? 32 : INDEX_WIDTH;

  // global advance: pipeline moves unless a finished beat is waiting
  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // bounds check, normalization, span and magnitude
  logic              n_valid;
  meta_t             n_meta;
  logic [QuotW-1:0]  n_num;
  logic [FieldW-1:0] n_mag;

  sin_norm #(.W(W)) u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .in_start  (req.range_start),
    .in_finish (req.range_finish),
    .in_step   (req.range_step),
    .in_dim    (req.dim_size),
    .out_valid (n_valid),
    .out_meta  (n_meta),
    .out_num   (n_num),
    .out_mag   (n_mag)
  );

  // length = (span - 1) / mag + 1, the ceiling of span over mag
  logic             d_valid;
  meta_t            d_meta;
  logic [QuotW-1:0] d_quot;

  sin_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (n_valid),
    .in_meta   (n_meta),
    .in_num    (n_num),
    .in_mag    (n_mag),
    .out_valid (d_valid),
    .out_meta  (d_meta),
    .out_quot  (d_quot)
  );

  // output register
  logic              out_valid;
  status_t           out_status;
  logic              out_remove;
  logic [DimW-1:0]   out_first;
  logic [FieldW-1:0] out_stride;
  logic [DimW-1:0]   out_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status <= d_meta.status;
      out_remove <= d_meta.remove_dim;
      out_first  <= d_meta.first_index;
      out_stride <= d_meta.index_stride;
      out_length <= d_meta.use_quot ? DimW'(d_quot + QuotW'(1)) : d_meta.fixed_length;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.remove_dim    = out_remove;
  assign rsp.first_index   = out_first;
  assign rsp.index_stride  = $signed(out_stride);
  assign rsp.result_length = out_length;

  // an error beat carries no selection
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.result_length == '0 && rsp.index_stride == '0
                                          && rsp.remove_dim == 1'b0)
    else $error("error beat with nonzero selection");

  // a single index always selects exactly one element
  a_single_len: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.remove_dim |-> rsp.result_length == DimW'(1)
                                    && rsp.status == ST_OK)
    else $error("single index beat with bad length");

  // a stalled output freezes the whole pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_length)
                                && $stable(rsp.first_index))
    else $error("output changed under stall");

  // nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("output valid right after reset");

endmodule
